### hdl/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

   localparam int PRIO_WIDTH    = 32;
   localparam int PAY_IO_WIDTH  = 32;
   localparam int HELD_WIDTH    = 7;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [0:0] {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

### hdl/min_priority_queue_linear_scan_top.sv
`default_nettype none

// Channel  Dir  Beat fields (lowest bit first)
// req_     in   tuser: action ; tdata: priority_in[31:0], payload_in[63:32]
// rsp_     out  tuser: status ; tdata: payload_out[31:0], entries_held[38:32], is_empty[39]
//
// An insert writes its entry at accept; its result beat is then registered in S_OUT.
// A remove sweeps the single read port of the entry memory one slot per cycle,
// then the last entry is written into the freed slot.
// Reset clears the entry count, the state and the valid flags; the entry memory is not cleared.
// One item is in work at a time; a result beat that is not taken holds off the
// next result, not the next accept.

module min_priority_queue_linear_scan_top
   import mpq_pkg::*;
#(
   parameter int CAPACITY      = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // priority_in, payload_in
   input  wire logic [0:0]               req_tuser,   // action
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,   // payload_out, entries_held, is_empty
   output logic      [1:0]               rsp_tuser    // status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = PRIO_WIDTH + PAYLOAD_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           scan_idx_ff, scan_idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [AW-1:0]           rd_idx_ff, rd_idx_in;
   logic [AW-1:0]           best_idx_ff, best_idx_in;
   logic [PRIO_WIDTH-1:0]   best_prio_ff, best_prio_in;
   logic [PAYLOAD_WIDTH-1:0] best_pay_ff, best_pay_in;
   status_type              res_status_ff, res_status_in;
   logic [PAY_IO_WIDTH-1:0] res_pay_ff, res_pay_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]              rsp_tuser_ff, rsp_tuser_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [EW-1:0]           rd_data;

   logic [PRIO_WIDTH-1:0]    rd_prio;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;
   logic                     cand_better;
   logic [AW-1:0]            fin_idx;
   logic [PAYLOAD_WIDTH-1:0] fin_pay;
   logic [AW-1:0]            last_idx;
   logic                     accept;
   logic                     out_free;
   logic                     full;
   logic [63:0]              pay_wide;

   // Each entry word holds the priority in its upper bits.
   mpq_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_prio  = rd_data[EW-1 -: PRIO_WIDTH];
   assign rd_pay   = rd_data[PAYLOAD_WIDTH-1:0];
   assign last_idx = AW'(count_ff - CW'(1));
   assign full     = (count_ff >= CW'(CAPACITY));
   assign pay_wide = {32'd0, req_tdata[63:32]};

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Strict less-than keeps the lowest slot among equal priorities.
   assign cand_better = rd_vld_ff &&
                        ((rd_idx_ff == '0) || ($signed(rd_prio) < $signed(best_prio_ff)));
   assign fin_idx = cand_better ? rd_idx_ff : best_idx_ff;
   assign fin_pay = cand_better ? rd_pay : best_pay_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_pay_in   = best_pay_ff;
      res_status_in = res_status_ff;
      res_pay_in    = res_pay_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {req_tdata[PRIO_WIDTH-1:0], PAYLOAD_WIDTH'(pay_wide)};
      rd_en         = 1'b0;
      rd_addr       = scan_idx_ff;

      if (cand_better) begin
         best_idx_in  = rd_idx_ff;
         best_prio_in = rd_prio;
         best_pay_in  = rd_pay;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_pay_in = '0;
               if (action_type'(req_tuser[0]) == ACT_INSERT) begin
                  state_in = S_OUT;
                  if (full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_status_in = STATUS_OK;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = S_OUT;
               end else begin
                  scan_idx_in = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            rd_idx_in = scan_idx_ff;
            if (scan_idx_ff == last_idx) begin
               state_in = S_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         S_LAST: begin
            // rd_data is the last stored entry: move it into the winner's slot
            wr_en         = 1'b1;
            wr_addr       = fin_idx;
            wr_data       = rd_data;
            count_in      = count_ff - CW'(1);
            res_status_in = STATUS_OK;
            res_pay_in    = PAY_IO_WIDTH'(fin_pay);
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = {(count_ff == '0), HELD_WIDTH'(count_ff), res_pay_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_pay_ff   <= best_pay_in;
      res_status_ff <= res_status_in;
      res_pay_ff    <= res_pay_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

### hdl/mpq_ram.sv
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### tb/tb_min_priority_queue_linear_scan_top.sv
`default_nettype none

module tb_min_priority_queue_linear_scan_top;
   import mpq_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = CAPACITY + 16;
   localparam int LONG_HOLD    = 600;

   typedef struct packed {
      status_type        status;
      logic [31:0]       payload;
      logic [6:0]        held;
      logic              is_empty;
   } rsp_beat_type;

   typedef struct {
      action_type        act;
      logic [31:0]       prio;
      logic [31:0]       pay;
      int                reps;
      bit                typed;
      rsp_beat_type      want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // priority_in, payload_in
   logic [0:0]               req_tuser = ACT_INSERT;   // action
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // payload_out, entries_held, is_empty
   logic [1:0]               rsp_tuser;   // status

   min_priority_queue_linear_scan_top #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the entry store
   logic signed [PRIO_WIDTH-1:0]   prio_shadow [CAPACITY];
   logic        [PAY_IO_WIDTH-1:0] pay_shadow  [CAPACITY];
   int                             shadow_count = 0;

   rsp_beat_type  awaited[$];
   stim_row_type  directed_rows[$];
   int         mismatches  = 0;
   int         beats_taken = 0;
   int         cycle_count = 0;
   int         burst_left  = 0;

   function automatic rsp_beat_type serve_request(action_type act, logic signed [31:0] prio,
                                                  logic [31:0] pay);
      rsp_beat_type r;
      int        best;
      int        i;
      r.status  = STATUS_OK;
      r.payload = '0;
      if (act == ACT_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            prio_shadow[shadow_count] = prio;
            pay_shadow[shadow_count]  = pay;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         // strict less-than keeps the lowest slot among equal priorities
         best = 0;
         for (i = 1; i < shadow_count; i++) begin
            if (prio_shadow[i] < prio_shadow[best]) best = i;
         end
         r.payload         = pay_shadow[best];
         prio_shadow[best] = prio_shadow[shadow_count-1];
         pay_shadow[best]  = pay_shadow[shadow_count-1];
         shadow_count--;
      end
      r.held     = shadow_count[6:0];
      r.is_empty = (shadow_count == 0);
      return r;
   endfunction

   task automatic add_row(action_type act, logic [31:0] prio, logic [31:0] pay, int reps,
                          bit typed, status_type st, logic [31:0] pay_out, int held,
                          bit is_empty);
      stim_row_type row;
      row.act          = act;
      row.prio         = prio;
      row.pay          = pay;
      row.reps         = reps;
      row.typed        = typed;
      row.want.status  = st;
      row.want.payload = pay_out;
      row.want.held    = held[6:0];
      row.want.is_empty = is_empty;
      directed_rows.push_back(row);
   endtask

   // one beat on the request side, with burst/gap pacing in front of it
   task automatic send_item(action_type act, logic [31:0] prio, logic [31:0] pay,
                            bit typed, rsp_beat_type want);
      rsp_beat_type predicted;
      int        gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= {$urandom, $urandom};
            req_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {pay, prio};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = serve_request(act, prio, pay);
      awaited.push_back(typed ? want : predicted);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_taken++;
         if (awaited.size() == 0) begin
            $error("response beat with nothing outstanding: tuser=%0d tdata=%h",
                   rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[31:0] !== want.payload) begin
               $error("payload_out: expected %h, got %h", want.payload, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[38:32] !== want.held) begin
               $error("entries_held: expected %0d, got %0d", want.held, rsp_tdata[38:32]);
               mismatches++;
            end
            if (rsp_tdata[39] !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_tdata[39]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: stretches of always-ready, random stalls, a fixed duty pattern and
   // mostly-stalled, plus one long hold-off so the request side backs up
   initial begin
      int  mode;
      int  span;
      int  phase;
      bit  held_off;
      phase    = 0;
      held_off = 0;
      forever begin
         if (!held_off && beats_taken >= 400) begin
            held_off = 1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
               @(negedge clock);
               phase++;
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= (phase % 4 != 3);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      rsp_beat_type   blank;
      stim_row_type   row;
      action_type  act;
      logic [31:0] prio;
      int          bias;
      int          seg;
      int          sent;
      int          k;
      blank = '0;

      // act, priority, payload, repeat, typed, status, payload_out, held, empty
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_EMPTY, 32'h0, 0, 1);
      add_row(ACT_INSERT, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h0, 1, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h0, 0, 1);
      add_row(ACT_INSERT, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 1, STATUS_OK, 32'h0, 1, 0);
      add_row(ACT_INSERT, 32'h80000000, 32'h00000001, 1, 1, STATUS_OK, 32'h0, 2, 0);
      add_row(ACT_INSERT, 32'hFFFFFFFF, 32'hA5A5A5A5, 1, 1, STATUS_OK, 32'h0, 3, 0);
      add_row(ACT_INSERT, 32'h00000001, 32'h5A5A5A5A, 1, 1, STATUS_OK, 32'h0, 4, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h00000001, 3, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'hA5A5A5A5, 2, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h5A5A5A5A, 1, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'hFFFFFFFF, 0, 1);
      add_row(ACT_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, STATUS_EMPTY, 32'h0, 0, 1);
      // three equal priorities: lowest slot wins, the last entry fills the hole
      add_row(ACT_INSERT, 32'd7,        32'h11,       1, 1, STATUS_OK, 32'h0, 1, 0);
      add_row(ACT_INSERT, 32'd7,        32'h22,       1, 1, STATUS_OK, 32'h0, 2, 0);
      add_row(ACT_INSERT, 32'd7,        32'h33,       1, 1, STATUS_OK, 32'h0, 3, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h11, 2, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h33, 1, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'h22, 0, 1);
      // fill to capacity, bounce off full, drain
      add_row(ACT_INSERT, 32'h40000000, 32'hC0DE0000, CAPACITY, 0, STATUS_OK, 32'h0, 0, 0);
      add_row(ACT_INSERT, 32'h80000000, 32'hFFFFFFFF, 1, 1, STATUS_FULL, 32'h0, CAPACITY, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        CAPACITY, 0, STATUS_OK, 32'h0, 0, 0);
      add_row(ACT_INSERT, 32'h80000000, 32'hFFFFFFFF, 1, 1, STATUS_OK, 32'h0, 1, 0);
      add_row(ACT_REMOVE, 32'h0,        32'h0,        1, 1, STATUS_OK, 32'hFFFFFFFF, 0, 1);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (k = 0; k < row.reps; k++) begin
            send_item(row.act, row.prio - k, row.pay + k, row.typed, row.want);
         end
      end

      // segments with a drifting insert/remove mix walk the count between empty and full
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: bias = 92;
            1: bias = 75;
            2: bias = 50;
            3: bias = 25;
            default: bias = 8;
         endcase
         seg = $urandom_range(16, 128);
         for (k = 0; k < seg && sent < RANDOM_ITEMS; k++) begin
            act = ($urandom_range(0, 99) < bias) ? ACT_INSERT : ACT_REMOVE;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: prio = $urandom;
               4, 5, 6:    prio = $urandom_range(0, 8) - 4;
               7: begin
                  case ($urandom_range(0, 3))
                     0: prio = 32'h80000000;
                     1: prio = 32'h7FFFFFFF;
                     2: prio = 32'h0;
                     default: prio = 32'hFFFFFFFF;
                  endcase
               end
               default: prio = $urandom_range(0, 2000) - 1000;
            endcase
            send_item(act, prio, $urandom, 1'b0, blank);
            sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

### min_priority_queue_linear_scan_top.f
hdl/mpq_pkg.sv
hdl/mpq_ram.sv
hdl/min_priority_queue_linear_scan_top.sv
tb/tb_min_priority_queue_linear_scan_top.sv
